[design/rsa_pkg.sv]
// ---------------------------------------------------------------------------
// rsa_pkg
// Shared types and constants of the reference-counted segregated allocator.
// ---------------------------------------------------------------------------
`default_nettype none

package rsa_pkg;

    // Granule store geometry
    localparam int STORE_DEPTH = 65536;
    localparam int ADDR_W      = 16;
    localparam int GRANULE_W   = 64;

    // Fill pointer and granule count width (covers 65536 and 131072)
    localparam int FILL_W = 18;
    localparam int GRAN_W = 18;

    // List walks stop after this many steps
    localparam logic [16:0] WALK_LIMIT = 17'h10000;

    // Refcount values
    localparam logic [31:0] REF_CONST = 32'hFFFF_FFFF;
    localparam logic [31:0] REF_MAX   = 32'h7FFF_FFFF;

    // Operation codes
    typedef enum logic [2:0] {
        OP_ALLOC     = 3'd0,
        OP_DETACH    = 3'd1,
        OP_ATTACH    = 3'd2,
        OP_CONST     = 3'd3,
        OP_PREDETACH = 3'd4
    } op_t;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_ZERO_SIZE = 3'd1,
        ST_TOO_LARGE = 3'd2,
        ST_NO_MEM    = 3'd3,
        ST_NULL      = 3'd4,
        ST_FREED     = 3'd5,
        ST_LEN_MISM  = 3'd6,
        ST_BAD_ADDR  = 3'd7
    } status_t;

    // Sequencer states
    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_A_CLS,
        S_A_HHDR,
        S_A_HLINK,
        S_L_START,
        S_L_HDR,
        S_L_LINK,
        S_L_SP1,
        S_L_SP2,
        S_L_SP3,
        S_L_SP5,
        S_L_RL,
        S_B_SCAN,
        S_B_NEW,
        S_Z_FILL,
        S_Z_HDR,
        S_O_HDR,
        S_R_START,
        S_R_CLS,
        S_R_WALK,
        S_R_WNEXT,
        S_R_LINK,
        S_R_RELINK,
        S_R_C1,
        S_R_C2,
        S_R_C3,
        S_R_C4,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

[design/refcounted_segregated_allocator_core.sv]
// ---------------------------------------------------------------------------
// refcounted_segregated_allocator_core
// Allocator over a 64-bit granule store with size-class lists, an address
// sorted large list, block fill pointers and signed header refcounts.
// ---------------------------------------------------------------------------
// Sequencing: refcount operations read and rewrite the header; allocation tries
// the class list, then the large list step by step, then scans the blocks, and
// zeroes the g data granules; a release walks the large list step by step.
// Throughput: one word at a time, set by the single port of the granule store.
// Reset: after rst_n rises, a sweep of SIZE_CLASSES cycles clears the class
// heads while in_ready stays low.
`default_nettype none

module refcounted_segregated_allocator_core
    import rsa_pkg::*;
#(
    parameter int SIZE_CLASSES   = 128,
    parameter int BLOCK_GRANULES = 16384,
    parameter int NUM_BLOCKS     = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  opcode,
    input  wire logic [19:0] size_bytes,
    input  wire logic [15:0] object_addr,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      result_addr,
    output logic [2:0]       status,
    output logic signed [31:0] ref_count
);

    localparam int CIW      = (SIZE_CLASSES > 1) ? $clog2(SIZE_CLASSES) : 1;
    localparam int BXW      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int BCW      = $clog2(NUM_BLOCKS + 1);
    localparam int FIT      = STORE_DEPTH / BLOCK_GRANULES;
    localparam int USABLE   = (FIT < NUM_BLOCKS) ? FIT : NUM_BLOCKS;

    state_t state_reg, state_next;

    // Request and walk registers
    logic [2:0]           op_reg;
    logic                 zero_size_reg;
    logic [GRAN_W-1:0]    g_reg;
    logic [ADDR_W-1:0]    a_reg;
    logic [ADDR_W-1:0]    cur_reg, prev_reg, nxt_reg, np_reg, p_reg;
    logic [ADDR_W-1:0]    large_head_reg;
    logic [63:0]          hdr_reg;
    logic [31:0]          ns_reg;
    logic [16:0]          steps_reg;
    logic [BCW-1:0]       blk_reg, opened_reg;
    logic                 new_reg;
    logic [GRAN_W-1:0]    cnt_reg;
    logic [CIW-1:0]       clr_reg;
    logic [FILL_W-1:0]    fill_reg [NUM_BLOCKS];

    // Staged result
    logic [ADDR_W-1:0]    res_addr_reg;
    logic [2:0]           res_status_reg;
    logic [31:0]          res_ref_reg;

    // Memory ports
    logic                 store_we;
    logic [ADDR_W-1:0]    store_addr;
    logic [63:0]          store_wdata, store_rdata;
    logic                 cls_we;
    logic [CIW-1:0]       cls_addr;
    logic [ADDR_W-1:0]    cls_wdata, cls_rdata;

    rsa_ram #(.WIDTH(GRANULE_W), .DEPTH(STORE_DEPTH)) u_store (
        .clk   (clk),
        .we    (store_we),
        .addr  (store_addr),
        .wdata (store_wdata),
        .rdata (store_rdata)
    );

    rsa_ram #(.WIDTH(ADDR_W), .DEPTH(SIZE_CLASSES)) u_class (
        .clk   (clk),
        .we    (cls_we),
        .addr  (cls_addr),
        .wdata (cls_wdata),
        .rdata (cls_rdata)
    );

    // Derived request values
    logic [GRAN_W-1:0] gm1, comb_g;
    logic [31:0]       len_req;
    logic              too_large, cls_hit;

    assign gm1       = g_reg - GRAN_W'(1);
    assign comb_g    = g_reg + GRAN_W'(1);
    assign len_req   = {11'b0, g_reg, 3'b0};
    assign too_large = ((32'(g_reg) + 32'd1) << 3) >= 32'(BLOCK_GRANULES);
    assign cls_hit   = 32'(gm1) < 32'(SIZE_CLASSES);

    // Large-list split decision
    logic [31:0]       cl, ns_calc, nidx;
    logic              exact_fit, split_ok, split_cls;
    logic [ADDR_W-1:0] np_calc;

    assign cl        = hdr_reg[63:32];
    assign exact_fit = (cl == len_req);
    assign split_ok  = {1'b0, cl} >= ({1'b0, len_req} + 33'd16);
    assign ns_calc   = cl - len_req - 32'd8;
    assign np_calc   = cur_reg + g_reg[ADDR_W-1:0] + ADDR_W'(1);
    assign nidx      = (ns_reg >> 3) - 32'd1;
    assign split_cls = nidx < 32'(SIZE_CLASSES);

    // Block fill pointer check
    logic [BXW-1:0]    bsel;
    logic [FILL_W-1:0] fill_sel, end_sel, room;
    logic              bump_ok;

    assign bsel     = BXW'(blk_reg - BCW'(1));
    assign fill_sel = fill_reg[bsel];
    assign end_sel  = FILL_W'(32'(blk_reg) * BLOCK_GRANULES);
    assign room     = end_sel - fill_sel;
    assign bump_ok  = room > FILL_W'(comb_g);

    // Address check against every opened block
    logic addr_ok;
    always_comb
    begin
        addr_ok = 1'b0;
        for (int b = 0; b < NUM_BLOCKS; b++)
        begin
            if ((BCW'(b) < opened_reg)
                && (32'(a_reg) >= 32'(b * BLOCK_GRANULES + 5))
                && ({2'b0, a_reg} < fill_reg[b]))
            begin
                addr_ok = 1'b1;
            end
        end
    end

    // Header fields of the object in hand
    logic [31:0] hr, hl, r_dec, r_inc;
    assign hr    = store_rdata[31:0];
    assign hl    = store_rdata[63:32];
    assign r_dec = hr - 32'd1;
    assign r_inc = (hr < REF_MAX) ? hr + 32'd1 : hr;

    // Release decisions
    logic [31:0]    rl_len, rl_g;
    logic           rl_big, rl_cls, rl_merge;
    logic [CIW-1:0] rl_cidx;

    assign rl_len   = hdr_reg[63:32];
    assign rl_g     = rl_len >> 3;
    assign rl_big   = ({1'b0, rl_len} + 33'd8) >= 33'(BLOCK_GRANULES);
    assign rl_cls   = (rl_g != 32'd0) && ((rl_g - 32'd1) < 32'(SIZE_CLASSES));
    assign rl_cidx  = CIW'(rl_g - 32'd1);
    assign rl_merge = (cur_reg != '0)
        && (({19'b0, a_reg, 3'b0} + 35'(rl_len) + 35'd8) == {16'b0, cur_reg, 3'b0});

    logic walk_end;
    assign walk_end = (cur_reg == '0) || (steps_reg == WALK_LIMIT);

    // Advance the sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
                if (clr_reg == CIW'(SIZE_CLASSES - 1)) state_next = S_IDLE;
            S_IDLE:
                if (in_valid) state_next = S_DECODE;
            S_DECODE:
                if (op_reg == OP_ALLOC)
                begin
                    if (zero_size_reg || too_large) state_next = S_DONE;
                    else if (cls_hit)               state_next = S_A_CLS;
                    else                            state_next = S_L_START;
                end
                else if (op_reg > OP_PREDETACH || a_reg == '0 || !addr_ok)
                    state_next = S_DONE;
                else
                    state_next = S_O_HDR;
            S_A_CLS:
                state_next = (cls_rdata != '0) ? S_A_HHDR : S_L_START;
            S_A_HHDR:
                state_next = (hl != len_req) ? S_DONE : S_A_HLINK;
            S_A_HLINK:
                state_next = S_Z_FILL;
            S_L_START:
                state_next = walk_end ? S_B_SCAN : S_L_HDR;
            S_L_HDR:
                state_next = S_L_LINK;
            S_L_LINK:
                if (exact_fit)     state_next = S_L_RL;
                else if (split_ok) state_next = S_L_SP1;
                else               state_next = S_L_START;
            S_L_SP1:
                state_next = S_L_SP2;
            S_L_SP2:
                state_next = split_cls ? S_L_SP3 : S_L_SP5;
            S_L_SP3:
                state_next = S_L_RL;
            S_L_SP5:
                state_next = S_L_RL;
            S_L_RL:
                state_next = S_Z_FILL;
            S_B_SCAN:
                if (blk_reg == '0)  state_next = S_B_NEW;
                else if (bump_ok)   state_next = S_Z_FILL;
                else if (new_reg)   state_next = S_DONE;
            S_B_NEW:
                state_next = (32'(opened_reg) < 32'(USABLE)) ? S_B_SCAN : S_DONE;
            S_Z_FILL:
                if (cnt_reg == gm1) state_next = S_Z_HDR;
            S_Z_HDR:
                state_next = S_DONE;
            S_O_HDR:
                if (op_reg == OP_DETACH && !hr[31] && hr != '0 && r_dec == '0)
                    state_next = S_R_START;
                else
                    state_next = S_DONE;
            S_R_START:
                if (rl_big)      state_next = S_DONE;
                else if (rl_cls) state_next = S_R_CLS;
                else             state_next = S_R_WALK;
            S_R_CLS:
                state_next = S_DONE;
            S_R_WALK:
                state_next = (walk_end || a_reg < cur_reg) ? S_R_LINK : S_R_WNEXT;
            S_R_WNEXT:
                state_next = S_R_WALK;
            S_R_LINK:
                state_next = S_R_RELINK;
            S_R_RELINK:
                state_next = rl_merge ? S_R_C1 : S_DONE;
            S_R_C1:
                state_next = S_R_C2;
            S_R_C2:
                state_next = S_R_C3;
            S_R_C3:
                state_next = S_R_C4;
            S_R_C4:
                state_next = S_DONE;
            S_DONE:
                if (!out_valid || out_ready) state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // Drive memory ports per state
    always_comb
    begin
        store_we    = 1'b0;
        store_addr  = '0;
        store_wdata = '0;
        cls_we      = 1'b0;
        cls_addr    = '0;
        cls_wdata   = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cls_we   = 1'b1;
                cls_addr = clr_reg;
            end
            S_DECODE:
            begin
                cls_addr   = CIW'(gm1);
                store_addr = a_reg - ADDR_W'(1);
            end
            S_A_CLS:
                store_addr = cls_rdata - ADDR_W'(1);
            S_A_HHDR:
                store_addr = p_reg;
            S_A_HLINK:
            begin
                cls_we    = 1'b1;
                cls_addr  = CIW'(gm1);
                cls_wdata = store_rdata[15:0];
            end
            S_L_START:
                store_addr = cur_reg - ADDR_W'(1);
            S_L_HDR:
                store_addr = cur_reg;
            S_L_SP1:
            begin
                store_we    = 1'b1;
                store_addr  = np_reg - ADDR_W'(1);
                store_wdata = {ns_reg, 32'd0};
            end
            S_L_SP2:
            begin
                store_we    = 1'b1;
                store_addr  = cur_reg - ADDR_W'(1);
                store_wdata = {len_req, hdr_reg[31:0]};
                cls_addr    = CIW'(nidx);
            end
            S_L_SP3:
            begin
                store_we    = 1'b1;
                store_addr  = np_reg;
                store_wdata = {48'd0, cls_rdata};
                cls_we      = 1'b1;
                cls_addr    = CIW'(nidx);
                cls_wdata   = np_reg;
            end
            S_L_SP5:
            begin
                store_we    = 1'b1;
                store_addr  = np_reg;
                store_wdata = {48'd0, nxt_reg};
            end
            S_L_RL:
            begin
                store_we    = (prev_reg != '0);
                store_addr  = prev_reg;
                store_wdata = {48'd0, nxt_reg};
            end
            S_Z_FILL:
            begin
                store_we   = 1'b1;
                store_addr = p_reg + cnt_reg[ADDR_W-1:0];
            end
            S_Z_HDR:
            begin
                store_we    = 1'b1;
                store_addr  = p_reg - ADDR_W'(1);
                store_wdata = {len_req, 32'd1};
            end
            S_O_HDR:
            begin
                store_addr  = a_reg - ADDR_W'(1);
                store_wdata = store_rdata;
                if (op_reg == OP_CONST)
                begin
                    store_we    = 1'b1;
                    store_wdata = {hl, REF_CONST};
                end
                else if (!hr[31] && hr != '0)
                begin
                    if (op_reg == OP_ATTACH)
                    begin
                        store_we    = 1'b1;
                        store_wdata = {hl, r_inc};
                    end
                    else if (op_reg == OP_DETACH || hr > 32'd1)
                    begin
                        store_we    = (r_dec != '0);
                        store_wdata = {hl, r_dec};
                    end
                end
            end
            S_R_START:
            begin
                store_we    = 1'b1;
                store_addr  = a_reg - ADDR_W'(1);
                store_wdata = {rl_len, 32'd0};
                cls_addr    = rl_cidx;
            end
            S_R_CLS:
            begin
                store_we    = 1'b1;
                store_addr  = a_reg;
                store_wdata = {48'd0, cls_rdata};
                cls_we      = 1'b1;
                cls_addr    = rl_cidx;
                cls_wdata   = a_reg;
            end
            S_R_WALK:
                store_addr = cur_reg;
            S_R_LINK:
            begin
                store_we    = 1'b1;
                store_addr  = a_reg;
                store_wdata = {48'd0, cur_reg};
            end
            S_R_RELINK:
            begin
                store_we    = (prev_reg != '0);
                store_addr  = prev_reg;
                store_wdata = {48'd0, a_reg};
            end
            S_R_C1:
                store_addr = cur_reg;
            S_R_C2:
            begin
                store_we    = 1'b1;
                store_addr  = a_reg;
                store_wdata = {48'd0, store_rdata[15:0]};
            end
            S_R_C3:
                store_addr = cur_reg - ADDR_W'(1);
            S_R_C4:
            begin
                store_we    = 1'b1;
                store_addr  = a_reg - ADDR_W'(1);
                store_wdata = {rl_len + hl + 32'd8, 32'd0};
            end
            default:
            begin
                store_we = 1'b0;
            end
        endcase
    end

    assign in_ready = (state_reg == S_IDLE);

    // Hold state, the large-list head, block fill pointers and the clearing count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            large_head_reg <= '0;
            opened_reg     <= '0;
            for (int b = 0; b < NUM_BLOCKS; b++)
            begin
                fill_reg[b] <= FILL_W'(b * BLOCK_GRANULES + 4);
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR) clr_reg <= clr_reg + CIW'(1);
            if (state_reg == S_L_RL && prev_reg == '0) large_head_reg <= nxt_reg;
            if (state_reg == S_R_RELINK && prev_reg == '0) large_head_reg <= a_reg;
            if (state_reg == S_B_NEW && 32'(opened_reg) < 32'(USABLE))
                opened_reg <= opened_reg + BCW'(1);
            if (state_reg == S_B_SCAN && blk_reg != '0 && bump_ok)
                fill_reg[bsel] <= fill_sel + FILL_W'(comb_g);
        end
    end

    // Work registers of the current request
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                op_reg         <= opcode;
                zero_size_reg  <= (size_bytes == '0);
                g_reg          <= GRAN_W'((21'(size_bytes) + 21'd7) >> 3);
                a_reg          <= object_addr;
                res_addr_reg   <= '0;
                res_status_reg <= ST_OK;
                res_ref_reg    <= '0;
            end
            S_DECODE:
            begin
                cur_reg   <= large_head_reg;
                prev_reg  <= '0;
                steps_reg <= '0;
                new_reg   <= 1'b0;
                if (op_reg == OP_ALLOC)
                begin
                    if (zero_size_reg)  res_status_reg <= ST_ZERO_SIZE;
                    else if (too_large) res_status_reg <= ST_TOO_LARGE;
                end
                else if (op_reg <= OP_PREDETACH)
                begin
                    if (a_reg == '0)   res_status_reg <= ST_NULL;
                    else if (!addr_ok) res_status_reg <= ST_BAD_ADDR;
                end
            end
            S_A_CLS:
                p_reg <= cls_rdata;
            S_A_HHDR:
                if (hl != len_req) res_status_reg <= ST_LEN_MISM;
            S_A_HLINK:
                cnt_reg <= '0;
            S_L_START:
                blk_reg <= opened_reg;
            S_L_HDR:
                hdr_reg <= store_rdata;
            S_L_LINK:
            begin
                nxt_reg   <= store_rdata[15:0];
                steps_reg <= steps_reg + 17'd1;
                ns_reg    <= ns_calc;
                np_reg    <= np_calc;
                if (!exact_fit && !split_ok)
                begin
                    prev_reg <= cur_reg;
                    cur_reg  <= store_rdata[15:0];
                end
            end
            S_L_SP5:
                nxt_reg <= np_reg;
            S_L_RL:
            begin
                p_reg   <= cur_reg;
                cnt_reg <= '0;
            end
            S_B_SCAN:
            begin
                cnt_reg <= '0;
                if (blk_reg != '0)
                begin
                    if (bump_ok)
                        p_reg <= fill_sel[ADDR_W-1:0] + ADDR_W'(1);
                    else if (new_reg)
                        res_status_reg <= ST_NO_MEM;
                    else
                        blk_reg <= blk_reg - BCW'(1);
                end
            end
            S_B_NEW:
            begin
                new_reg <= 1'b1;
                blk_reg <= opened_reg + BCW'(1);
                if (32'(opened_reg) >= 32'(USABLE)) res_status_reg <= ST_NO_MEM;
            end
            S_Z_FILL:
                cnt_reg <= cnt_reg + GRAN_W'(1);
            S_Z_HDR:
            begin
                res_addr_reg <= p_reg;
                res_ref_reg  <= 32'd1;
            end
            S_O_HDR:
            begin
                hdr_reg <= store_rdata;
                if (op_reg == OP_CONST || hr[31])
                    res_ref_reg <= REF_CONST;
                else if (hr == '0)
                    res_status_reg <= ST_FREED;
                else if (op_reg == OP_ATTACH)
                    res_ref_reg <= r_inc;
                else if (op_reg == OP_DETACH || hr > 32'd1)
                    res_ref_reg <= r_dec;
                else
                begin
                    res_ref_reg  <= hr;
                    res_addr_reg <= a_reg;
                end
            end
            S_R_WNEXT:
            begin
                prev_reg  <= cur_reg;
                cur_reg   <= store_rdata[15:0];
                steps_reg <= steps_reg + 17'd1;
            end
            default:
            begin
                new_reg <= new_reg;
            end
        endcase
    end

    // Output register: load a finished result when the slot is free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (state_reg == S_DONE && (!out_valid || out_ready))
        begin
            out_valid <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_DONE && (!out_valid || out_ready))
        begin
            result_addr <= res_addr_reg;
            status      <= res_status_reg;
            ref_count   <= res_ref_reg;
        end
    end

`ifndef ASSERT_OFF
    a_accept_decodes: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == S_DECODE)
        else $error("accepted word did not start decoding");

    a_opened_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(opened_reg) <= 32'(USABLE))
        else $error("more blocks opened than fit in the store");

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !store_we && !cls_we)
        else $error("memory written while idle");

    a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLEAR |-> !in_ready && !out_valid)
        else $error("input taken during class head sweep");
`endif

endmodule

`default_nettype wire

[design/rsa_ram.sv]
// ---------------------------------------------------------------------------
// rsa_ram
// Single-port synchronous RAM with one write port and a registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module rsa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and read the addressed word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

[tb/refcounted_segregated_allocator_core_tb.sv]
// ---------------------------------------------------------------------------
// refcounted_segregated_allocator_core_tb
// Drives allocate, detach, attach, make-constant and predetach requests into
// the allocator, keeps a shadow copy of the granule store, lists and fill
// pointers, and checks every returned word against the shadow's prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module refcounted_segregated_allocator_core_tb;
    import rsa_pkg::*;

    localparam int NCLASS  = 128;
    localparam int BLKG    = 16384;
    localparam int NBLK    = 4;
    localparam int NITEMS  = 700;

    typedef struct packed {
        logic [15:0] addr;
        logic [2:0]  st;
        logic [31:0] rc;
    } reply_t;

    // Shadow allocator and queue of expected replies
    class alloc_scoreboard;
        logic [63:0] granules [int];
        logic [15:0] class_head [NCLASS];
        logic [15:0] large_head;
        int unsigned fill [NBLK];
        int unsigned opened;
        reply_t      expected_replies [$];
        int          errors;

        function new();
            large_head = '0;
            opened     = 0;
            errors     = 0;
            foreach (class_head[i]) class_head[i] = '0;
            foreach (fill[b]) fill[b] = b * BLKG + 4;
        endfunction

        function logic [63:0] rd(logic [15:0] a);
            if (granules.exists(int'(a))) return granules[int'(a)];
            return '0;
        endfunction

        function logic [31:0] ref_of(logic [15:0] a);
            logic [15:0] h;
            h = a - 16'd1;
            return rd(h)[31:0];
        endfunction

        function logic [31:0] len_of(logic [15:0] a);
            logic [15:0] h;
            h = a - 16'd1;
            return rd(h)[63:32];
        endfunction

        function void set_hdr(logic [15:0] a, logic [31:0] r, logic [31:0] l);
            logic [15:0] h;
            h = a - 16'd1;
            granules[int'(h)] = {l, r};
        endfunction

        function logic [15:0] link_of(logic [15:0] a);
            return rd(a)[15:0];
        endfunction

        function void set_link(logic [15:0] a, logic [15:0] v);
            granules[int'(a)] = {48'd0, v};
        endfunction

        function void relink(logic [15:0] prev, logic [15:0] v);
            if (prev != 0) set_link(prev, v);
            else large_head = v;
        endfunction

        function bit addr_ok(logic [15:0] a);
            for (int unsigned b = 0; b < opened && b < NBLK; b++)
                if (a >= b * BLKG + 5 && a < fill[b]) return 1'b1;
            return 1'b0;
        endfunction

        // Take the first entry that fits exactly or is big enough to split
        function logic [15:0] take_large(int unsigned g);
            longint unsigned len, cl, ns, nidx, steps;
            logic [15:0] prev, cur, nxt, np;
            len = g * 8; prev = '0; cur = large_head; steps = 0;
            while (cur != 0 && steps < 65536) begin
                cl  = len_of(cur);
                nxt = link_of(cur);
                steps++;
                if (cl == len) begin
                    relink(prev, nxt);
                    return cur;
                end
                if (cl >= len + 16) begin
                    ns   = cl - len - 8;
                    np   = cur + 16'(g + 1);
                    nidx = 32'((ns >> 3) - 1);
                    set_hdr(np, '0, 32'(ns));
                    set_hdr(cur, ref_of(cur), 32'(len));
                    if (nidx < NCLASS) begin
                        set_link(np, class_head[nidx]);
                        class_head[nidx] = np;
                        relink(prev, nxt);
                    end else begin
                        set_link(np, nxt);
                        relink(prev, np);
                    end
                    return cur;
                end
                prev = cur;
                cur  = nxt;
            end
            return '0;
        endfunction

        function logic [15:0] bump(int unsigned b, int unsigned comb);
            int unsigned top, p;
            top = b * BLKG + BLKG;
            if (top - fill[b] <= comb) return '0;
            p = fill[b] + 1;
            fill[b] += comb;
            return 16'(p);
        endfunction

        // Free an object: drop it if block-sized, else class list, or sorted large list with forward merge
        function void free_object(logic [15:0] a);
            longint unsigned len, g, steps;
            logic [15:0] prev, cur;
            len = len_of(a); g = len >> 3;
            prev = '0; cur = large_head; steps = 0;
            set_hdr(a, '0, 32'(len));
            if (len + 8 >= BLKG) return;
            if (g >= 1 && g - 1 < NCLASS) begin
                set_link(a, class_head[g-1]);
                class_head[g-1] = a;
                return;
            end
            while (cur != 0 && steps < 65536) begin
                if (a < cur) break;
                prev = cur;
                cur  = link_of(cur);
                steps++;
            end
            set_link(a, cur);
            relink(prev, a);
            if (cur != 0 && longint'(a) * 8 + len + 8 == longint'(cur) * 8) begin
                set_link(a, link_of(cur));
                set_hdr(a, '0, 32'(len + len_of(cur) + 8));
            end
        endfunction

        function reply_t allocate(logic [19:0] size);
            reply_t      r;
            int unsigned g;
            logic [15:0] p, h;
            r = '0; p = '0;
            if (size == 0) begin
                r.st = ST_ZERO_SIZE;
                return r;
            end
            g = (int'(size) + 7) >> 3;
            if ((g + 1) * 8 >= BLKG) begin
                r.st = ST_TOO_LARGE;
                return r;
            end
            if (g - 1 < NCLASS) begin
                h = class_head[g-1];
                if (h != 0) begin
                    if (len_of(h) != g * 8) begin
                        r.st = ST_LEN_MISM;
                        return r;
                    end
                    class_head[g-1] = link_of(h);
                    p = h;
                end
            end
            if (p == 0) p = take_large(g);
            for (int unsigned i = opened; p == 0 && i > 0; i--)
                if (i - 1 < NBLK) p = bump(i - 1, g + 1);
            if (p == 0 && opened < NBLK) begin
                opened++;
                p = bump(opened - 1, g + 1);
            end
            if (p == 0) begin
                r.st = ST_NO_MEM;
                return r;
            end
            for (int unsigned i = 0; i < g; i++) granules[int'(p + 16'(i))] = '0;
            set_hdr(p, 32'd1, 32'(g * 8));
            r.addr = p;
            r.rc   = 32'd1;
            return r;
        endfunction

        function reply_t predict(logic [2:0] op, logic [19:0] size, logic [15:0] a);
            reply_t      r;
            logic [31:0] rc;
            r = '0;
            if (op == OP_ALLOC) return allocate(size);
            if (op > OP_PREDETACH) return r;
            if (a == 0) begin
                r.st = ST_NULL;
                return r;
            end
            if (!addr_ok(a)) begin
                r.st = ST_BAD_ADDR;
                return r;
            end
            rc = ref_of(a);
            if (op == OP_CONST) begin
                set_hdr(a, REF_CONST, len_of(a));
                r.rc = REF_CONST;
                return r;
            end
            if (rc[31]) begin
                r.rc = REF_CONST;
                return r;
            end
            if (rc == 0) begin
                r.st = ST_FREED;
                return r;
            end
            if (op == OP_ATTACH) begin
                if (rc < REF_MAX) rc++;
                set_hdr(a, rc, len_of(a));
            end else if (op == OP_DETACH) begin
                rc--;
                if (rc == 0) free_object(a);
                else set_hdr(a, rc, len_of(a));
            end else begin
                if (rc > 1) begin
                    rc--;
                    set_hdr(a, rc, len_of(a));
                end else begin
                    r.addr = a;
                end
            end
            r.rc = rc;
            return r;
        endfunction

        function reply_t note_request(logic [2:0] op, logic [19:0] size, logic [15:0] a);
            reply_t r;
            r = predict(op, size, a);
            expected_replies.push_back(r);
            return r;
        endfunction

        function void check_result(logic [15:0] addr, logic [2:0] st, logic [31:0] rc);
            reply_t e;
            if (expected_replies.size() == 0) begin
                $display("%0t: unexpected word addr=%h status=%0d ref=%h", $time, addr, st, rc);
                errors++;
                return;
            end
            e = expected_replies.pop_front();
            if (addr !== e.addr) begin
                $display("%0t: result_addr expected %h actual %h", $time, e.addr, addr);
                errors++;
            end
            if (st !== e.st) begin
                $display("%0t: status expected %0d actual %0d", $time, e.st, st);
                errors++;
            end
            if (rc !== e.rc) begin
                $display("%0t: ref_count expected %h actual %h", $time, e.rc, rc);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  opcode;
    logic [19:0] size_bytes;
    logic [15:0] object_addr;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] result_addr;
    logic [2:0]  status;
    logic signed [31:0] ref_count;

    alloc_scoreboard sb;
    logic [15:0] live_objs [$];
    logic [15:0] dead_objs [$];
    logic [15:0] const_objs [$];
    int          burst_left;
    int unsigned rx_cycle;

    refcounted_segregated_allocator_core i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .size_bytes  (size_bytes),
        .object_addr (object_addr),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_addr (result_addr),
        .status      (status),
        .ref_count   (ref_count)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // Drop an object from every pool
    function void purge(logic [15:0] a);
        for (int i = live_objs.size() - 1; i >= 0; i--)
            if (live_objs[i] == a) live_objs.delete(i);
        for (int i = dead_objs.size() - 1; i >= 0; i--)
            if (dead_objs[i] == a) dead_objs.delete(i);
        for (int i = const_objs.size() - 1; i >= 0; i--)
            if (const_objs[i] == a) const_objs.delete(i);
    endfunction

    // Send one word, note it, and file the touched object by its new refcount
    task automatic send_request(logic [2:0] op, logic [19:0] size, logic [15:0] a);
        reply_t      r;
        logic [31:0] rc;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 120)
                                                     : $urandom_range(1, 12);
            @(negedge clk);
            in_valid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end else begin
            @(negedge clk);
        end
        burst_left--;
        in_valid    = 1'b1;
        opcode      = op;
        size_bytes  = size;
        object_addr = a;
        do @(posedge clk); while (!in_ready);
        r = sb.note_request(op, size, a);
        if (op == OP_ALLOC && r.st == ST_OK) begin
            purge(r.addr);
            live_objs.push_back(r.addr);
        end else if (op != OP_ALLOC && op <= OP_PREDETACH && a != 0
                     && (r.st == ST_OK || r.st == ST_FREED)) begin
            purge(a);
            rc = sb.ref_of(a);
            if (rc == 0) dead_objs.push_back(a);
            else if (rc == REF_CONST) const_objs.push_back(a);
            else live_objs.push_back(a);
        end
    endtask

    function logic [19:0] pick_size();
        int unsigned k;
        k = $urandom_range(0, 99);
        if (k < 55) return 20'($urandom_range(1, 128));
        if (k < 75) return 20'($urandom_range(129, 1024));
        if (k < 90) return 20'($urandom_range(1025, 8192));
        if (k < 95) return 20'($urandom_range(8193, 16368));
        return 20'($urandom_range(0, 20'hFFFFF));
    endfunction

    // Result side: stall pattern steps through four modes, chosen from rx_cycle
    initial
    begin
        out_ready = 1'b0;
        rx_cycle  = 0;
        forever
        begin
            @(negedge clk);
            rx_cycle++;
            case ((rx_cycle / 500) % 4)
                0: out_ready = 1'b1;
                1: out_ready = $urandom_range(0, 1);
                2: out_ready = (rx_cycle % 7) < 3;
                default: out_ready = $urandom_range(0, 7) != 0;
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(result_addr, status, ref_count);
    end

    // Overall time limit
    initial
    begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] d;
        logic [15:0] e;
        int unsigned k;
        int unsigned idx;
        logic [2:0]  op;
        sb          = new();
        burst_left  = 0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        opcode      = '0;
        size_bytes  = '0;
        object_addr = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: error codes, class reuse, large split and constants
        send_request(OP_ALLOC, 20'd0, 16'd0);
        send_request(OP_ALLOC, 20'hFFFFF, 16'hFFFF);
        send_request(OP_ALLOC, 20'd16369, 16'd0);
        send_request(OP_DETACH, 20'd0, 16'd0);
        send_request(OP_ATTACH, 20'd0, 16'd0);
        send_request(OP_CONST, 20'd0, 16'd0);
        send_request(OP_PREDETACH, 20'd0, 16'd0);
        send_request(3'd5, 20'hFFFFF, 16'hFFFF);
        send_request(3'd6, 20'd0, 16'd0);
        send_request(3'd7, 20'hFFFFF, 16'hFFFF);
        send_request(OP_DETACH, 20'd0, 16'hFFFF);
        send_request(OP_ALLOC, 20'd8, 16'd0);
        a = live_objs[$];
        send_request(OP_ALLOC, 20'd1, 16'd0);
        b = live_objs[$];
        send_request(OP_ALLOC, 20'd1024, 16'd0);
        send_request(OP_ALLOC, 20'd1025, 16'd0);
        d = live_objs[$];
        send_request(OP_ALLOC, 20'd16368, 16'd0);
        e = live_objs[$];
        send_request(OP_ATTACH, 20'd0, a);
        send_request(OP_PREDETACH, 20'd0, a);
        send_request(OP_PREDETACH, 20'd0, a);
        send_request(OP_DETACH, 20'd0, a);
        send_request(OP_DETACH, 20'd0, a);
        send_request(OP_ALLOC, 20'd8, 16'd0);
        send_request(OP_DETACH, 20'd0, d);
        send_request(OP_ALLOC, 20'd100, 16'd0);
        send_request(OP_DETACH, 20'd0, e);
        send_request(OP_CONST, 20'd0, b);
        send_request(OP_DETACH, 20'd0, b);

        // Random traffic, mostly on live objects
        for (int n = 0; n < NITEMS; n++)
        begin
            if (n == NITEMS / 2)
            begin
                @(negedge clk);
                in_valid = 1'b0;
                while (sb.expected_replies.size() != 0) @(posedge clk);
                burst_left = 1;
            end
            k = $urandom_range(0, 99);
            if (live_objs.size() > 80 && k < 35) k = 40;
            if (live_objs.size() == 0 && k >= 35 && k < 88) k = 0;
            if (k < 35) begin
                send_request(OP_ALLOC, pick_size(), 16'($urandom_range(0, 65535)));
            end else if (k < 88) begin
                idx = $urandom_range(0, live_objs.size() - 1);
                a   = live_objs[idx];
                if (k < 65) op = OP_DETACH;
                else if (k < 80) op = OP_ATTACH;
                else if (k < 85) op = OP_PREDETACH;
                else op = OP_CONST;
                send_request(op, 20'($urandom_range(0, 20'hFFFFF)), a);
            end else if (k < 93) begin
                // Old objects: freed ones, or constants
                if (k < 91 && dead_objs.size() != 0) begin
                    idx = $urandom_range(0, dead_objs.size() - 1);
                    a   = dead_objs[idx];
                    if (!sb.addr_ok(a) || sb.ref_of(a) != 0) begin
                        dead_objs.delete(idx);
                        continue;
                    end
                    op = 3'($urandom_range(OP_DETACH, OP_ATTACH));
                    if ($urandom_range(0, 2) == 0) op = OP_PREDETACH;
                end else if (const_objs.size() != 0) begin
                    a  = const_objs[$urandom_range(0, const_objs.size() - 1)];
                    op = 3'($urandom_range(OP_DETACH, OP_PREDETACH));
                end else begin
                    continue;
                end
                send_request(op, 20'd0, a);
            end else begin
                // Noise: null, stray addresses and unused opcodes
                a  = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(0, 65535));
                op = 3'($urandom_range(1, 7));
                if (a != 0 && op <= OP_PREDETACH && sb.addr_ok(a)) continue;
                send_request(op, 20'($urandom_range(0, 20'hFFFFF)), a);
            end
        end

        // Drain and finish
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.expected_replies.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
